### hdl/mrof_pkg.sv
`default_nettype none
package mrof_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_WAIT,
        ST_RANK,
        ST_SAT,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic write_pixel;
        logic gather_start;
        logic gather_step;
        logic rank_start;
        logic rank_step;
        logic sat_step;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic load_inside;
        logic gather_last;
        logic rank_last;
        logic found;
    } status_t;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned SIZE_W = 9;
    localparam int unsigned MASK_W = 64;
    localparam int unsigned MCELLS = 64;

    localparam logic [2:0] REG_WIDTH = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MASK = 3'd2;
    localparam logic [2:0] REG_CCOL = 3'd3;
    localparam logic [2:0] REG_CROW = 3'd4;
    localparam logic [2:0] REG_RANK = 3'd5;

endpackage
`default_nettype wire

### hdl/mrof_ctrl.sv
`default_nettype none
module mrof_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire mrof_pkg::status_t  status,
    output mrof_pkg::cmd_t          cmd
);

    mrof_pkg::state_t state_reg;
    mrof_pkg::state_t state_next;
    logic             busy_reg;
    logic             busy_next;
    logic             accept;

    assign accept = in_valid && !busy_reg;
    assign in_stall = busy_reg;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrof_pkg::ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            mrof_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mrof_pkg::ST_WAIT;
                    busy_next  = 1'b1;
                end
            end
            mrof_pkg::ST_WAIT:
            begin
                if (status.is_query)
                begin
                    state_next = mrof_pkg::ST_GATHER;
                end
                else
                begin
                    state_next = mrof_pkg::ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            mrof_pkg::ST_GATHER:
            begin
                if (status.gather_last)
                begin
                    state_next = mrof_pkg::ST_RANK;
                end
            end
            mrof_pkg::ST_RANK:
            begin
                if (status.rank_last)
                begin
                    state_next = mrof_pkg::ST_SAT;
                end
            end
            mrof_pkg::ST_SAT:
            begin
                if (status.found)
                begin
                    state_next = mrof_pkg::ST_OUT;
                end
            end
            mrof_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = mrof_pkg::ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = mrof_pkg::ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        out_valid = 1'b0;
        case (state_reg)
            mrof_pkg::ST_IDLE:
            begin
                cmd.capture = accept;
            end
            mrof_pkg::ST_WAIT:
            begin
                cmd.write_pixel  = !status.is_query && status.load_inside;
                cmd.gather_start = status.is_query;
            end
            mrof_pkg::ST_GATHER:
            begin
                cmd.gather_step = 1'b1;
                cmd.rank_start  = status.gather_last;
            end
            mrof_pkg::ST_RANK:
            begin
                cmd.rank_step = 1'b1;
            end
            mrof_pkg::ST_SAT:
            begin
                cmd.sat_step    = 1'b1;
                cmd.load_result = status.found;
            end
            mrof_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/mrof_datapath.sv
`default_nettype none
module mrof_datapath
#(
    parameter int unsigned MAX_SIDE  = 256,
    parameter int unsigned MASK_SIDE = 8
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [mrof_pkg::MASK_W-1:0]   cfg_data,
    input  wire logic                          action,
    input  wire logic [7:0]                    col,
    input  wire logic [7:0]                    row,
    input  wire logic [7:0]                    pixel_in,
    input  wire mrof_pkg::cmd_t                cmd,
    output mrof_pkg::status_t                  status,
    output logic [7:0]                         filtered_value
);

    localparam int unsigned SIDE_W = $clog2(MAX_SIDE);
    localparam int unsigned ADDR_W = 2 * SIDE_W;
    localparam int unsigned DEPTH  = 1 << ADDR_W;
    localparam int unsigned CRD_W  = ((SIDE_W > 8) ? SIDE_W : 8) + 2;

    // Configuration registers.
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [63:0] mask_reg;
    logic [2:0]  ccol_reg;
    logic [2:0]  crow_reg;
    logic [5:0]  rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            mask_reg   <= 64'd1;
            ccol_reg   <= 3'd0;
            crow_reg   <= 3'd0;
            rank_reg   <= 6'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mrof_pkg::REG_WIDTH:  width_reg  <= cfg_data[8:0];
                mrof_pkg::REG_HEIGHT: height_reg <= cfg_data[8:0];
                mrof_pkg::REG_MASK:   mask_reg   <= cfg_data;
                mrof_pkg::REG_CCOL:   ccol_reg   <= cfg_data[2:0];
                mrof_pkg::REG_CROW:   crow_reg   <= cfg_data[2:0];
                mrof_pkg::REG_RANK:   rank_reg   <= cfg_data[5:0];
                default:              ;
            endcase
        end
    end

    // Effective frame size, clamped to the store side.
    logic [CRD_W-1:0] eff_w;
    logic [CRD_W-1:0] eff_h;
    assign eff_w = (32'(width_reg) > MAX_SIDE) ? CRD_W'(MAX_SIDE) : CRD_W'(width_reg);
    assign eff_h = (32'(height_reg) > MAX_SIDE) ? CRD_W'(MAX_SIDE) : CRD_W'(height_reg);

    // Captured transaction.
    logic       action_reg;
    logic [7:0] col_reg;
    logic [7:0] row_reg;
    logic [7:0] pix_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            col_reg    <= col;
            row_reg    <= row;
            pix_reg    <= pixel_in;
        end
    end

    assign status.is_query    = action_reg;
    assign status.load_inside = (CRD_W'(col_reg) < eff_w) && (CRD_W'(row_reg) < eff_h);

    // Gather counter walks the 64 mask cells, one per cycle.
    logic [6:0] cell_reg;
    logic [2:0] mc;
    logic [2:0] mr;
    logic       cell_used;
    logic signed [CRD_W:0] nx;
    logic signed [CRD_W:0] ny;
    logic       in_frame;

    assign mc = cell_reg[2:0];
    assign mr = cell_reg[5:3];
    assign cell_used = !cell_reg[6] && mask_reg[cell_reg[5:0]]
                       && (32'(mc) < MASK_SIDE) && (32'(mr) < MASK_SIDE);
    assign nx = $signed({1'b0, CRD_W'(col_reg)}) + $signed({1'b0, CRD_W'(mc)})
                - $signed({1'b0, CRD_W'(ccol_reg)});
    assign ny = $signed({1'b0, CRD_W'(row_reg)}) + $signed({1'b0, CRD_W'(mr)})
                - $signed({1'b0, CRD_W'(crow_reg)});
    assign in_frame = (nx >= 0) && (ny >= 0)
                      && (nx < $signed({1'b0, eff_w})) && (ny < $signed({1'b0, eff_h}));
    assign status.gather_last = cell_reg[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (cmd.gather_start)
            cell_reg <= '0;
        else if (cmd.gather_step && !cell_reg[6])
            cell_reg <= cell_reg + 7'd1;
    end

    // Frame store, single port with registered read data.
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_addr = {SIDE_W'(row_reg), SIDE_W'(col_reg)};
    assign rd_addr = {ny[SIDE_W-1:0], nx[SIDE_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.write_pixel)
            mem[wr_addr] <= pix_reg;
        else
            rd_reg <= mem[rd_addr];
    end

    // Gather flags are registered so that they line up with the registered read data.
    logic       pend_valid_reg;
    logic       pend_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_inside_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg  <= cmd.gather_step && cell_used;
            pend_inside_reg <= in_frame;
        end
    end

    // Neighbour buffer and count.
    logic [7:0] nb_reg [mrof_pkg::MCELLS];
    logic [6:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.gather_start)
            count_reg <= '0;
        else if (pend_valid_reg)
            count_reg <= count_reg + 7'd1;
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_reg)
            nb_reg[count_reg[5:0]] <= pend_inside_reg ? rd_reg : 8'd0;
    end

    // Rank by counting: for candidate i, count neighbours below it and equal.
    // Candidate i is the answer when less <= target < less + equal.
    // Buffer reads are registered, so for each candidate the scan reads every
    // neighbour in turn, then finishes the last compare, then decides.
    logic [6:0] cand_reg;
    logic [6:0] scan_reg;
    logic [6:0] less_reg;
    logic [6:0] eq_reg;
    logic [7:0] best_reg;
    logic       found_reg;
    logic       cmp_valid_reg;
    logic [7:0] cand_val_reg;
    logic [7:0] scan_val_reg;
    logic [5:0] target;
    logic       scan_done;

    assign target = (7'(rank_reg) < count_reg) ? rank_reg : 6'(count_reg - 7'd1);
    assign scan_done = (scan_reg > count_reg);
    assign status.rank_last = 1'b1;
    assign status.found = found_reg || (count_reg == 7'd0) || (cand_reg >= count_reg);

    // Registered reads of the neighbour buffer for the comparator.
    always_ff @(posedge clk)
    begin
        cand_val_reg <= nb_reg[cand_reg[5:0]];
        scan_val_reg <= nb_reg[scan_reg[5:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg      <= '0;
            scan_reg      <= '0;
            less_reg      <= '0;
            eq_reg        <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.rank_start)
        begin
            cand_reg      <= '0;
            scan_reg      <= '0;
            less_reg      <= '0;
            eq_reg        <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.sat_step && !status.found)
        begin
            cmp_valid_reg <= !scan_done && (scan_reg < count_reg);
            if (scan_done)
            begin
                if ((7'(target) >= less_reg) && (7'(target) < less_reg + eq_reg))
                begin
                    found_reg <= 1'b1;
                    best_reg  <= cand_val_reg;
                end
                cand_reg <= cand_reg + 7'd1;
                scan_reg <= '0;
                less_reg <= '0;
                eq_reg   <= '0;
            end
            else
            begin
                scan_reg <= scan_reg + 7'd1;
                if (cmp_valid_reg)
                begin
                    if (scan_val_reg < cand_val_reg)
                        less_reg <= less_reg + 7'd1;
                    else if (scan_val_reg == cand_val_reg)
                        eq_reg <= eq_reg + 7'd1;
                end
            end
        end
    end

    // Output register.
    logic [7:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
            out_reg <= found_reg ? best_reg : 8'd0;
    end

    assign filtered_value = out_reg;

    logic unused;
    assign unused = cmd.rank_step;

endmodule
`default_nettype wire

### hdl/masked_rank_order_filter_2d.sv
// Rank-order filter with an 8x8 structuring mask over a stored 8-bit frame.
// Input channel (in_valid/in_stall) carries one transaction: action, col,
// row and pixel_in. action 0 writes the pixel into the frame store when it
// lies inside the configured frame and returns nothing; action 1 returns one
// filtered_value on the output channel (out_valid/out_stall).
// Configuration is to be written through cfg_write/cfg_index/cfg_data only
// while idle; the user is bound to this, the block does not enforce it. One
// transaction is handled at a time; in_stall is high while it is at work.
// A query walks the 64 mask cells through the single-port frame store, then
// runs the counting rank search over the n used neighbours with the shared
// comparator loop and registered buffer reads, then loads the result into
// the output register.
// The result holds on the output while out_stall is high; the next
// transaction is taken once the result has been accepted.
// Reset clears the control state and restores the configuration defaults;
// the frame store content is undefined until written.
`default_nettype none
module masked_rank_order_filter_2d
#(
    parameter int unsigned MAX_SIDE  = 256,
    parameter int unsigned MASK_SIDE = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [7:0]  col,
    input  wire logic [7:0]  row,
    input  wire logic [7:0]  pixel_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       filtered_value
);

    mrof_pkg::cmd_t    cmd;
    mrof_pkg::status_t status;

    // Sequencer.
    mrof_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Frame store, gather and rank datapath.
    mrof_datapath #(
        .MAX_SIDE  (MAX_SIDE),
        .MASK_SIDE (MASK_SIDE)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .col            (col),
        .row            (row),
        .pixel_in       (pixel_in),
        .cmd            (cmd),
        .status         (status),
        .filtered_value (filtered_value)
    );

endmodule
`default_nettype wire

### tb/sv/masked_rank_order_filter_2d_checker.sv
`default_nettype none
module masked_rank_order_filter_2d_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        action,
    input  wire logic [7:0]  col,
    input  wire logic [7:0]  row,
    input  wire logic [7:0]  pixel_in,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  filtered_value,
    output int               failures,
    output int               pending
);

    logic [mrof_pkg::PIX_W-1:0]  pixel_mem [0:65535];
    logic [mrof_pkg::SIZE_W-1:0] width_reg;
    logic [mrof_pkg::SIZE_W-1:0] height_reg;
    logic [mrof_pkg::MASK_W-1:0] mask_reg;
    logic [2:0]        ccol_reg;
    logic [2:0]        crow_reg;
    logic [5:0]        rank_reg;
    logic [7:0]        ranked_values [$];

    // Sort the masked neighbourhood by histogram and pick the requested rank.
    function automatic logic [7:0] ranked_neighbour(input int x, input int y);
        int hist [256];
        int count;
        int w;
        int h;
        int nx;
        int ny;
        int target;
        int acc;
        logic [7:0] val;
        count = 0;
        w = (width_reg > 256) ? 256 : int'(width_reg);
        h = (height_reg > 256) ? 256 : int'(height_reg);
        for (int v = 0; v < 256; v++)
            hist[v] = 0;
        for (int mr = 0; mr < 8; mr++)
        begin
            for (int mc = 0; mc < 8; mc++)
            begin
                if (mask_reg[mr*8+mc])
                begin
                    nx = x + mc - int'(ccol_reg);
                    ny = y + mr - int'(crow_reg);
                    val = 8'd0;
                    if (nx >= 0 && nx < w && ny >= 0 && ny < h)
                        val = pixel_mem[ny*256+nx];
                    hist[val]++;
                    count++;
                end
            end
        end
        if (count == 0)
            return 8'd0;
        target = (int'(rank_reg) < count) ? int'(rank_reg) : count - 1;
        acc = 0;
        for (int v = 0; v < 256; v++)
        begin
            acc += hist[v];
            if (acc > target)
                return v[7:0];
        end
        return 8'hFF;
    endfunction

    // Track configuration and loads, predict on each query, compare outputs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            mask_reg   <= 64'd1;
            ccol_reg   <= 3'd0;
            crow_reg   <= 3'd0;
            rank_reg   <= 6'd0;
            failures   <= 0;
            pending    <= 0;
            ranked_values.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mrof_pkg::REG_WIDTH:  width_reg  <= cfg_data[8:0];
                    mrof_pkg::REG_HEIGHT: height_reg <= cfg_data[8:0];
                    mrof_pkg::REG_MASK:   mask_reg   <= cfg_data;
                    mrof_pkg::REG_CCOL:   ccol_reg   <= cfg_data[2:0];
                    mrof_pkg::REG_CROW:   crow_reg   <= cfg_data[2:0];
                    mrof_pkg::REG_RANK:   rank_reg   <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (action == 1'b0)
                begin
                    if (col < ((width_reg > 256) ? 256 : width_reg)
                        && row < ((height_reg > 256) ? 256 : height_reg))
                        pixel_mem[row*256+col] = pixel_in;
                end
                else
                    ranked_values.push_back(ranked_neighbour(col, row));
            end
            if (out_valid && !out_stall)
            begin
                if (ranked_values.size() == 0)
                begin
                    $error("unexpected output transaction: filtered_value %0d",
                           filtered_value);
                    failures <= failures + 1;
                end
                else if (ranked_values[0] !== filtered_value)
                begin
                    $error("filtered_value mismatch: expected %0d, actual %0d",
                           ranked_values[0], filtered_value);
                    failures <= failures + 1;
                    void'(ranked_values.pop_front());
                end
                else
                    void'(ranked_values.pop_front());
            end
            pending <= ranked_values.size();
        end
    end

endmodule
`default_nettype wire

### tb/sv/masked_rank_order_filter_2d_test.sv
`default_nettype none
module masked_rank_order_filter_2d_test;

    localparam logic [2:0] REG_SPARE = 3'd6;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam int STALL_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [63:0] cfg_data = 64'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [7:0]  col = 8'd0;
    logic [7:0]  row = 8'd0;
    logic [7:0]  pixel_in = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  filtered_value;
    int          failures;
    int          pending;

    // Host copy of the frame settings, used only to shape legal stimulus.
    bit          written [0:65535];
    int          host_w = 256;
    int          host_h = 256;
    logic [63:0] host_mask = 64'd1;
    int          host_ccol = 0;
    int          host_crow = 0;
    bit          calm = 1'b0;
    bit          long_hold = 1'b0;
    int          quiet_cycles = 0;

    masked_rank_order_filter_2d dut (.*);

    masked_rank_order_filter_2d_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on cycles in which no transaction moves.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Register write, issued only once the block has gone idle.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_stall || pending != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mrof_pkg::REG_WIDTH:  host_w = (val[8:0] > 256) ? 256 : int'(val[8:0]);
            mrof_pkg::REG_HEIGHT: host_h = (val[8:0] > 256) ? 256 : int'(val[8:0]);
            mrof_pkg::REG_MASK:   host_mask = val;
            mrof_pkg::REG_CCOL:   host_ccol = int'(val[2:0]);
            mrof_pkg::REG_CROW:   host_crow = int'(val[2:0]);
            default: ;
        endcase
    endtask

    // Offer one transaction and hold it until it is taken.
    task automatic send_item(input logic a, input logic [7:0] c, input logic [7:0] r,
                             input logic [7:0] p);
        in_valid <= 1'b1;
        action <= a;
        col <= c;
        row <= r;
        pixel_in <= p;
        do
            @(posedge clk);
        while (in_stall);
        if (a == ACT_LOAD && c < host_w && r < host_h)
            written[r*256+c] = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // First in-frame neighbour of a query that has never been loaded, or -1.
    function automatic int unloaded_neighbour(input int x, input int y);
        int nx;
        int ny;
        for (int mr = 0; mr < 8; mr++)
        begin
            for (int mc = 0; mc < 8; mc++)
            begin
                nx = x + mc - host_ccol;
                ny = y + mr - host_crow;
                if (host_mask[mr*8+mc] && nx >= 0 && nx < host_w && ny >= 0
                    && ny < host_h && !written[ny*256+nx])
                    return ny*256 + nx;
            end
        end
        return -1;
    endfunction

    // A query, preceded by the loads that its neighbourhood still lacks.
    task automatic send_query(input logic [7:0] c, input logic [7:0] r);
        int addr;
        addr = unloaded_neighbour(c, r);
        while (addr >= 0)
        begin
            send_item(ACT_LOAD, addr[7:0], addr[15:8], 8'($urandom));
            addr = unloaded_neighbour(c, r);
        end
        send_item(ACT_QUERY, c, r, 8'($urandom));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [63:0] sparse_mask;
        logic [63:0] m;
        m = 64'd0;
        repeat ($urandom_range(1, 6))
            m[$urandom_range(0, 63)] = 1'b1;
        return m;
    endfunction

    function automatic logic [8:0] random_side;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 9'd0;
        if (pick == 1)
            return 9'($urandom_range(257, 511));
        if (pick < 5)
            return 9'($urandom_range(200, 256));
        return 9'($urandom_range(1, 16));
    endfunction

    initial
    begin
        int mode;
        int n_items;
        int xr;
        int yr;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full mask at the frame corners with the largest rank.
        write_reg(mrof_pkg::REG_WIDTH, 64'd256);
        write_reg(mrof_pkg::REG_HEIGHT, 64'd256);
        write_reg(mrof_pkg::REG_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(mrof_pkg::REG_CCOL, 64'd7);
        write_reg(mrof_pkg::REG_CROW, 64'd7);
        write_reg(mrof_pkg::REG_RANK, 64'd63);
        write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(ACT_LOAD, 8'd255, 8'd255, 8'd255);
        send_item(ACT_LOAD, 8'd0, 8'd0, 8'd0);
        send_query(8'd255, 8'd255);
        send_query(8'd0, 8'd0);
        drain();

        // Directed: rank zero, tiny and empty frames, empty mask, loads outside.
        write_reg(mrof_pkg::REG_RANK, 64'd0);
        write_reg(mrof_pkg::REG_CCOL, 64'd0);
        write_reg(mrof_pkg::REG_CROW, 64'd0);
        send_query(8'd255, 8'd255);
        send_query(8'd250, 8'd251);
        write_reg(mrof_pkg::REG_WIDTH, 64'd1);
        write_reg(mrof_pkg::REG_HEIGHT, 64'd1);
        send_item(ACT_LOAD, 8'd0, 8'd0, 8'd170);
        send_item(ACT_LOAD, 8'd1, 8'd0, 8'd85);
        send_item(ACT_LOAD, 8'd0, 8'd128, 8'd85);
        send_query(8'd0, 8'd0);
        send_query(8'd255, 8'd0);
        write_reg(mrof_pkg::REG_MASK, 64'd0);
        send_query(8'd0, 8'd0);
        write_reg(mrof_pkg::REG_MASK, 64'h8000_0000_0000_0001);
        write_reg(mrof_pkg::REG_WIDTH, 64'd0);
        write_reg(mrof_pkg::REG_HEIGHT, 64'd511);
        send_query(8'd0, 8'd0);
        send_query(8'd128, 8'd127);
        drain();

        // Random phases; the last few run without idling.
        for (int ph = 0; ph < 24; ph++)
        begin
            calm = (ph >= 21);
            write_reg(mrof_pkg::REG_WIDTH, 64'(random_side()));
            write_reg(mrof_pkg::REG_HEIGHT, 64'(random_side()));
            write_reg(mrof_pkg::REG_CCOL, 64'($urandom_range(0, 7)));
            write_reg(mrof_pkg::REG_CROW, 64'($urandom_range(0, 7)));
            write_reg(mrof_pkg::REG_RANK, 64'($urandom_range(0, 63)));
            mode = (ph % 6 == 3) ? 1 : ((ph % 6 == 5) ? 2 : ((ph == 10) ? 3 : 0));
            case (mode)
                1: write_reg(mrof_pkg::REG_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
                2: write_reg(mrof_pkg::REG_MASK, {$urandom, $urandom});
                3: write_reg(mrof_pkg::REG_MASK, 64'd0);
                default: write_reg(mrof_pkg::REG_MASK, sparse_mask());
            endcase
            n_items = (mode == 1 || mode == 2) ? 10 : 85;
            if (ph == 4)
                long_hold = 1'b1;
            for (int i = 0; i < n_items; i++)
            begin
                if (ph == 7 && i == 40)
                    drain();
                if ($urandom_range(0, 9) < 4)
                begin
                    if ($urandom_range(0, 5) == 0 || host_w == 0 || host_h == 0)
                        send_item(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
                    else
                        send_item(ACT_LOAD, 8'($urandom_range(0, host_w - 1)),
                                  8'($urandom_range(0, host_h - 1)), 8'($urandom));
                end
                else if ($urandom_range(0, 4) == 0 || host_w == 0 || host_h == 0)
                    send_query(8'($urandom), 8'($urandom));
                else
                begin
                    xr = $urandom_range(0, host_w - 1);
                    yr = $urandom_range(0, host_h - 1);
                    send_query(8'(xr), 8'(yr));
                end
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
hdl/mrof_pkg.sv
hdl/mrof_ctrl.sv
hdl/mrof_datapath.sv
hdl/masked_rank_order_filter_2d.sv
tb/sv/masked_rank_order_filter_2d_checker.sv
tb/sv/masked_rank_order_filter_2d_test.sv
